@@ hw/rtl/pfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared constants for the page frame pool: defaults, field widths and codes.
// ----------------------------------------------------------------------------
package pfp_pkg;

	localparam int FRAMES_DEF     = 16;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MAX_PINS_DEF   = 255;
	localparam int MAX_AGE_DEF    = 255;

	localparam int PAGE_W   = 32;
	localparam int STATUS_W = 3;
	localparam int FIDX_W   = 4;
	localparam int IO_W     = 2;
	localparam int OFFSET_W = 44;

	// operation codes
	localparam logic OP_GET   = 1'b0;
	localparam logic OP_UNPIN = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNPINNED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_RES   = 3'd4;

	// I/O request codes
	localparam logic [IO_W-1:0] IO_NONE  = 2'd0;
	localparam logic [IO_W-1:0] IO_READ  = 2'd1;
	localparam logic [IO_W-1:0] IO_WRITE = 2'd2;

endpackage

@@ hw/rtl/page_frame_pool_lru.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_pool_lru
// Page frame pool with age-based LRU replacement and pin counts.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op, page_number and modified and raise start; the
//   transaction is taken at the edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status,
//   frame_index, io_request and io_offset valid in that cycle. The receiver
//   cannot stall; every result must be taken when done is high.
// Sequencing:
//   From acceptance to the result strobe a transaction makes one pass of the
//   frame RAM read port over every frame (aging, lookup and victim search
//   share that pass), waits for the registered RAM read data of the last
//   read, and then makes the final entry update in S_DONE. busy drops in
//   the cycle done rises, so the next transaction is taken at the edge that
//   ends the strobe cycle; none is taken while one is in flight.
// Reset:
//   arst_n clears all frame valid bits and the control state; the frame RAM
//   needs no clearing, since pin count and age of a frame are written when
//   it is filled and never used while it is invalid.
// ----------------------------------------------------------------------------
module page_frame_pool_lru
	import pfp_pkg::*;
#(
	parameter int FRAMES     = FRAMES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF,
	parameter int MAX_PINS   = MAX_PINS_DEF,
	parameter int MAX_AGE    = MAX_AGE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                op,
	input  logic [PAGE_W-1:0]   page_number,
	input  logic                modified,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [FIDX_W-1:0]   frame_index,
	output logic [IO_W-1:0]     io_request,
	output logic [OFFSET_W-1:0] io_offset
);

	localparam int IDX_W  = $clog2(FRAMES);
	localparam int CNT_W  = IDX_W + 1;
	localparam int PIN_W  = $clog2(MAX_PINS + 1);
	localparam int AGE_W  = $clog2(MAX_AGE + 1);
	localparam int PB_W   = $clog2(PAGE_BYTES + 1);
	localparam int PROD_W = (PAGE_W + PB_W > OFFSET_W) ? PAGE_W + PB_W : OFFSET_W;
	localparam int ENT_W  = PAGE_W + PIN_W + AGE_W;

	localparam logic [PIN_W-1:0] PIN_MAX  = PIN_W'(MAX_PINS);
	localparam logic [AGE_W-1:0] AGE_MAX  = AGE_W'(MAX_AGE);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAMES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(FRAMES);
	localparam logic [PB_W-1:0]  PB       = PB_W'(PAGE_BYTES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	typedef struct packed {
		logic [PAGE_W-1:0] tag;
		logic [PIN_W-1:0]  pin;
		logic [AGE_W-1:0]  age;
	} entry_t;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  iss_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [FRAMES-1:0] valid_q;

	// latched command
	logic              op_q;
	logic [PAGE_W-1:0] page_q;
	logic              mod_q;

	// scan trackers
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [PIN_W-1:0]  hit_pin_q;
	logic [AGE_W-1:0]  hit_age_q;
	logic              inv_q;
	logic [IDX_W-1:0]  inv_idx_q;
	logic              vic_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [AGE_W-1:0]  vic_age_q;

	// RAM port
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            ram_rdata;
	logic [ENT_W-1:0]  ram_rdata_raw;

	// per-entry scan view
	logic              cur_valid;
	logic [AGE_W-1:0]  cur_aged;
	logic              cur_match;

	// final update
	logic              fill_ok;
	logic [IDX_W-1:0]  fill_idx;
	logic [PIN_W-1:0]  pin_up;
	logic [PIN_W-1:0]  pin_dn;
	logic [PROD_W-1:0] prod;

	assign busy      = (state_q != S_IDLE);
	assign ram_rdata = entry_t'(ram_rdata_raw);

	pfp_frame_ram #(
		.DEPTH  (FRAMES),
		.DATA_W (ENT_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	// Age saturates; a get ages before the lookup, an unpin never ages.
	always_comb begin
		cur_valid = valid_q[idx_s1];
		cur_aged  = ram_rdata.age;
		if ((op_q == OP_GET) && (ram_rdata.age < AGE_MAX)) begin
			cur_aged = ram_rdata.age + AGE_W'(1);
		end
		cur_match = cur_valid && (ram_rdata.tag == page_q);
	end

	always_comb begin
		fill_ok  = inv_q || vic_q;
		fill_idx = inv_q ? inv_idx_q : vic_idx_q;
		pin_up   = (hit_pin_q < PIN_MAX) ? hit_pin_q + PIN_W'(1) : hit_pin_q;
		pin_dn   = (hit_pin_q != '0) ? hit_pin_q - PIN_W'(1) : hit_pin_q;
		prod     = PROD_W'(page_q) * PROD_W'(PB);
	end

	// Read address: issue index for the scan, frame 0 on acceptance.
	always_comb begin
		ram_raddr = '0;
		if (state_q == S_SCAN) begin
			ram_raddr = iss_q[IDX_W-1:0];
		end
	end

	// Write port: aged write-back during a get scan, entry update at the end.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = '{tag: ram_rdata.tag, pin: ram_rdata.pin, age: cur_aged};
		unique case (state_q)
			S_SCAN: begin
				ram_we = pend_s1 && (op_q == OP_GET);
			end
			S_DONE: begin
				if (op_q == OP_GET) begin
					if (hit_q) begin
						ram_we    = 1'b1;
						ram_waddr = hit_idx_q;
						ram_wdata = '{tag: page_q, pin: pin_up, age: '0};
					end else begin
						ram_we    = fill_ok;
						ram_waddr = fill_idx;
						ram_wdata = '{tag: page_q, pin: PIN_W'(1), age: '0};
					end
				end else begin
					ram_we    = hit_q;
					ram_waddr = hit_idx_q;
					ram_wdata = '{tag: page_q, pin: pin_dn, age: hit_age_q};
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			valid_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pend_s1 <= (iss_q < CNT_END);
					if (pend_s1 && (idx_s1 == IDX_LAST)) begin
						state_q <= S_DONE;
						pend_s1 <= 1'b0;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
					if ((op_q == OP_GET) && !hit_q && fill_ok) begin
						valid_q[fill_idx] <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: command latch, scan trackers, result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				// take the transaction, reset trackers, start issuing at frame 0
				op_q   <= op;
				page_q <= page_number;
				mod_q  <= modified;
				iss_q  <= '0;
				hit_q  <= 1'b0;
				inv_q  <= 1'b0;
				vic_q  <= 1'b0;
			end
			S_SCAN: begin
				if (iss_q < CNT_END) begin
					idx_s1 <= iss_q[IDX_W-1:0];
					iss_q  <= iss_q + CNT_W'(1);
				end
				if (pend_s1) begin
					if (cur_match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
						hit_pin_q <= ram_rdata.pin;
						hit_age_q <= cur_aged;
					end
					if (!cur_valid && !inv_q) begin
						inv_q     <= 1'b1;
						inv_idx_q <= idx_s1;
					end
					// strictly greater keeps the lowest index on ties
					if (cur_valid && (ram_rdata.pin == '0) &&
					    (!vic_q || (cur_aged > vic_age_q))) begin
						vic_q     <= 1'b1;
						vic_idx_q <= idx_s1;
						vic_age_q <= cur_aged;
					end
				end
			end
			S_DONE: begin
				frame_index <= '0;
				io_request  <= IO_NONE;
				io_offset   <= '0;
				if (op_q == OP_GET) begin
					if (hit_q) begin
						status      <= ST_HIT;
						frame_index <= FIDX_W'(hit_idx_q);
					end else if (fill_ok) begin
						status      <= ST_MISS;
						frame_index <= FIDX_W'(fill_idx);
						io_request  <= IO_READ;
						io_offset   <= prod[OFFSET_W-1:0];
					end else begin
						status <= ST_NO_VICTIM;
					end
				end else begin
					if (hit_q) begin
						status      <= ST_UNPINNED;
						frame_index <= FIDX_W'(hit_idx_q);
						if (mod_q) begin
							io_request <= IO_WRITE;
							io_offset  <= prod[OFFSET_W-1:0];
						end
					end else begin
						status <= ST_NOT_RES;
					end
				end
			end
			default: begin
				iss_q <= '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/pfp_frame_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_frame_ram
// Frame entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfp_frame_ram #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 48,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
